[hw/rtl/greedy_meshlet_partitioner_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the greedy meshlet partitioner
// ----------------------------------------------------------------------------
`ifndef GREEDY_MESHLET_PARTITIONER_TOP_DEFINES_SVH
`define GREEDY_MESHLET_PARTITIONER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet during reset
`define GMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet during reset
`define GMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/gmp_pkg.sv]
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared types and constants of the greedy meshlet partitioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmp_pkg;

    localparam int MAX_DISTINCT_DEF      = 64;
    localparam int VERTEX_INDEX_BITS_DEF = 32;

    localparam int IN_VERTEX_W  = 32;
    localparam int NUMBER_W     = 24;
    localparam int COUNT_W      = 7;
    localparam int VLIM_W       = 7;
    localparam int ILIM_W       = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [VLIM_W-1:0] VERTEX_LIMIT_RESET = 7'd64;
    localparam logic [ILIM_W-1:0] INDEX_LIMIT_RESET  = 8'd128;
    localparam logic [ILIM_W-1:0] TRI_INDICES        = 8'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_VERTEX_LIMIT = 2'd0,
        CFG_INDEX_LIMIT  = 2'd1
    } cfg_reg_e;

    typedef struct packed {
        logic [IN_VERTEX_W-1:0] vertex_a;
        logic [IN_VERTEX_W-1:0] vertex_b;
        logic [IN_VERTEX_W-1:0] vertex_c;
        logic                   mesh_end;
    } tri_in_t;

    typedef struct packed {
        logic [NUMBER_W-1:0] meshlet_number;
        logic                opens_meshlet;
        logic                closes_meshlet;
        logic [COUNT_W-1:0]  distinct_count;
    } tri_out_t;

    // One flag per triangle corner
    typedef struct packed {
        logic a;
        logic b;
        logic c;
    } corner_t;

endpackage

[hw/rtl/gmp_cell.sv]
// ----------------------------------------------------------------------------
// gmp_cell
// One entry of the meshlet vertex set: holds a vertex index and compares it
// against all three corners of the incoming triangle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmp_cell #(
    parameter int VERTEX_INDEX_BITS = gmp_pkg::VERTEX_INDEX_BITS_DEF
) (
    input  logic                         clk,
    input  logic [VERTEX_INDEX_BITS-1:0] vertex_a,
    input  logic [VERTEX_INDEX_BITS-1:0] vertex_b,
    input  logic [VERTEX_INDEX_BITS-1:0] vertex_c,
    input  gmp_pkg::corner_t             wsel,
    output gmp_pkg::corner_t             match
);
    import gmp_pkg::*;

    logic [VERTEX_INDEX_BITS-1:0] entry_reg;
    logic [VERTEX_INDEX_BITS-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        priority if (wsel.a)
        begin
            entry_next = vertex_a;
        end
        else if (wsel.b)
        begin
            entry_next = vertex_b;
        end
        else if (wsel.c)
        begin
            entry_next = vertex_c;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign match.a = (entry_reg == vertex_a);
    assign match.b = (entry_reg == vertex_b);
    assign match.c = (entry_reg == vertex_c);

endmodule

[hw/rtl/gmp_merge.sv]
// ----------------------------------------------------------------------------
// gmp_merge
// Combines the per-entry matches into membership per corner, removes
// duplicates within the triangle and assigns the append slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmp_merge #(
    parameter int CELLS             = gmp_pkg::MAX_DISTINCT_DEF + 2,
    parameter int FILL_W            = $clog2(gmp_pkg::MAX_DISTINCT_DEF + 3),
    parameter int VERTEX_INDEX_BITS = gmp_pkg::VERTEX_INDEX_BITS_DEF
) (
    input  logic                               en,
    input  logic [FILL_W-1:0]                  fill_base,
    input  logic [VERTEX_INDEX_BITS-1:0]       vertex_a,
    input  logic [VERTEX_INDEX_BITS-1:0]       vertex_b,
    input  logic [VERTEX_INDEX_BITS-1:0]       vertex_c,
    input  gmp_pkg::corner_t [CELLS-1:0]       match,
    output gmp_pkg::corner_t [CELLS-1:0]       wsel,
    output logic [FILL_W-1:0]                  fill_new
);
    import gmp_pkg::*;

    corner_t           hit;
    corner_t           fresh;
    logic [FILL_W-1:0] slot_a;
    logic [FILL_W-1:0] slot_b;
    logic [FILL_W-1:0] slot_c;

    // Only entries below the fill count belong to the open meshlet
    always_comb
    begin
        hit = '0;
        for (int i = 0; i < CELLS; i++)
        begin
            if (FILL_W'(i) < fill_base)
            begin
                hit.a = hit.a | match[i].a;
                hit.b = hit.b | match[i].b;
                hit.c = hit.c | match[i].c;
            end
        end
    end

    always_comb
    begin
        fresh.a  = !hit.a;
        fresh.b  = !hit.b && (vertex_b != vertex_a);
        fresh.c  = !hit.c && (vertex_c != vertex_a) && (vertex_c != vertex_b);
        slot_a   = fill_base;
        slot_b   = slot_a + FILL_W'(fresh.a);
        slot_c   = slot_b + FILL_W'(fresh.b);
        fill_new = slot_c + FILL_W'(fresh.c);
    end

    always_comb
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            wsel[i].a = en && fresh.a && (slot_a == FILL_W'(i));
            wsel[i].b = en && fresh.b && (slot_b == FILL_W'(i));
            wsel[i].c = en && fresh.c && (slot_c == FILL_W'(i));
        end
    end

endmodule

[hw/rtl/greedy_meshlet_partitioner_top.sv]
// The result word of an accepted triangle is registered and shows next cycle.
// Throughput: one triangle per cycle unless out_ready stalls output, set by the
// combinational compare of three corners to all set entries and the merge.
// Reset clears the meshlet state, the counter and the output stage, and sets
// the limits to 64 vertices and 128 indices; set entries are not cleared.
// ----------------------------------------------------------------------------
// greedy_meshlet_partitioner_top
// Streams triangles into meshlets bounded by distinct-vertex and index limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "greedy_meshlet_partitioner_top_defines.svh"

module greedy_meshlet_partitioner_top #(
    parameter int MAX_DISTINCT      = gmp_pkg::MAX_DISTINCT_DEF,
    parameter int VERTEX_INDEX_BITS = gmp_pkg::VERTEX_INDEX_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  gmp_pkg::tri_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output gmp_pkg::tri_out_t                   out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gmp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gmp_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import gmp_pkg::*;

    localparam int CELLS  = MAX_DISTINCT + 2;
    localparam int FILL_W = $clog2(MAX_DISTINCT + 3);
    localparam int LIM_W  = (FILL_W > VLIM_W) ? FILL_W : VLIM_W;

    logic                         in_fire;
    logic [VERTEX_INDEX_BITS-1:0] va;
    logic [VERTEX_INDEX_BITS-1:0] vb;
    logic [VERTEX_INDEX_BITS-1:0] vc;

    logic                  open_reg;
    logic                  open_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [FILL_W-1:0]     fill_next;
    logic [ILIM_W-1:0]     tally_reg;
    logic [ILIM_W-1:0]     tally_next;
    logic [NUMBER_W-1:0]   counter_reg;
    logic [NUMBER_W-1:0]   counter_next;
    logic [VLIM_W-1:0]     vertex_limit_reg;
    logic [VLIM_W-1:0]     vertex_limit_next;
    logic [ILIM_W-1:0]     index_limit_reg;
    logic [ILIM_W-1:0]     index_limit_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    tri_out_t              out_data_reg;
    tri_out_t              out_data_next;

    logic [FILL_W-1:0]     fill_base;
    logic [FILL_W-1:0]     fill_new;
    logic [ILIM_W-1:0]     tally_new;
    logic [LIM_W-1:0]      vlim_eff;
    logic                  closes;

    corner_t [CELLS-1:0]   match;
    corner_t [CELLS-1:0]   wsel;

    assign va = in_data.vertex_a[VERTEX_INDEX_BITS-1:0];
    assign vb = in_data.vertex_b[VERTEX_INDEX_BITS-1:0];
    assign vc = in_data.vertex_c[VERTEX_INDEX_BITS-1:0];

    // Take a new triangle whenever the output stage is empty or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // A closed meshlet reads as an empty set
    assign fill_base = open_reg ? fill_reg : '0;
    assign tally_new = (open_reg ? tally_reg : '0) + TRI_INDICES;

    generate
        for (genvar g = 0; g < CELLS; g++)
        begin : g_cell
            gmp_cell #(
                .VERTEX_INDEX_BITS(VERTEX_INDEX_BITS)
            ) u_cell (
                .clk      (clk),
                .vertex_a (va),
                .vertex_b (vb),
                .vertex_c (vc),
                .wsel     (wsel[g]),
                .match    (match[g])
            );
        end
    endgenerate

    gmp_merge #(
        .CELLS            (CELLS),
        .FILL_W           (FILL_W),
        .VERTEX_INDEX_BITS(VERTEX_INDEX_BITS)
    ) u_merge (
        .en        (in_fire),
        .fill_base (fill_base),
        .vertex_a  (va),
        .vertex_b  (vb),
        .vertex_c  (vc),
        .match     (match),
        .wsel      (wsel),
        .fill_new  (fill_new)
    );

    // Saturate the vertex limit at the set capacity
    always_comb
    begin
        if (LIM_W'(vertex_limit_reg) > LIM_W'(MAX_DISTINCT))
        begin
            vlim_eff = LIM_W'(MAX_DISTINCT);
        end
        else
        begin
            vlim_eff = LIM_W'(vertex_limit_reg);
        end
        closes = (LIM_W'(fill_new) >= vlim_eff) || (tally_new >= index_limit_reg)
                 || in_data.mesh_end;
    end

    always_comb
    begin
        open_next         = open_reg;
        fill_next         = fill_reg;
        tally_next        = tally_reg;
        counter_next      = counter_reg;
        vertex_limit_next = vertex_limit_reg;
        index_limit_next  = index_limit_reg;
        out_valid_next    = out_valid_reg;
        out_data_next     = out_data_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_fire)
        begin
            open_next                    = !closes;
            fill_next                    = fill_new;
            tally_next                   = tally_new;
            out_valid_next               = 1'b1;
            out_data_next.meshlet_number = counter_reg;
            out_data_next.opens_meshlet  = !open_reg;
            out_data_next.closes_meshlet = closes;
            out_data_next.distinct_count = COUNT_W'(fill_new);
            if (closes)
            begin
                counter_next = in_data.mesh_end ? '0 : counter_reg + NUMBER_W'(1);
            end
        end

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_e'(cfg_index))
                CFG_VERTEX_LIMIT: vertex_limit_next = cfg_data[VLIM_W-1:0];
                CFG_INDEX_LIMIT:  index_limit_next  = cfg_data[ILIM_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg         <= 1'b0;
            fill_reg         <= '0;
            tally_reg        <= '0;
            counter_reg      <= '0;
            vertex_limit_reg <= VERTEX_LIMIT_RESET;
            index_limit_reg  <= INDEX_LIMIT_RESET;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            open_reg         <= open_next;
            fill_reg         <= fill_next;
            tally_reg        <= tally_next;
            counter_reg      <= counter_next;
            vertex_limit_reg <= vertex_limit_next;
            index_limit_reg  <= index_limit_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    `GMP_ASSERT_NEXT(a_close_ends_meshlet, in_fire && closes, !open_reg, "closed meshlet still open")
    `GMP_ASSERT_NEXT(a_mesh_end_restarts, in_fire && in_data.mesh_end, (counter_reg == '0) && !open_reg, "meshlet number not restarted at mesh end")
    `GMP_ASSERT_IMP(a_open_word_count, out_valid && out_data.opens_meshlet, (out_data.distinct_count >= 7'd1) && (out_data.distinct_count <= 7'd3), "opening word with bad distinct count")

endmodule
